>>> design/eapg_pkg.sv
// Package for the ellipse arc point generator: sizes, register indexes,
// the CORDIC arctangent table and the angle folding helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eapg_pkg;

	localparam int CORDIC_STAGES    = 16;
	localparam int DEFAULT_SEGMENTS = 64;
	localparam int DIV_BITS         = 45;
	localparam int LAT              = DIV_BITS + CORDIC_STAGES + 5;
	localparam int CW               = 34;
	localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);

	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_SEMI_MAJOR  = 3'd2,
		REG_AXIS_RATIO  = 3'd3,
		REG_ROT_ANGLE   = 3'd4,
		REG_START_PARAM = 3'd5,
		REG_END_PARAM   = 3'd6,
		REG_SEG_COUNT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic                 flip;
	} fold_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// fold a turn angle into [-1/4, +1/4] turn, flip marks a half-turn shift
	function automatic fold_t fold_angle(input logic [31:0] ang);
		fold_t f;
		logic signed [CW-1:0] z;
		z = CW'($signed(ang));
		f.flip = 1'b0;
		f.z = z;
		if (z > $signed(CW'(34'sh040000000))) begin
			f.z = z - $signed(CW'(34'sh080000000));
			f.flip = 1'b1;
		end else if (z < -$signed(CW'(34'sh040000000))) begin
			f.z = z + $signed(CW'(34'sh080000000));
			f.flip = 1'b1;
		end
		return f;
	endfunction

endpackage
`default_nettype wire

>>> design/eapg_div_cell.sv
// One restoring division cell: one quotient bit per cycle while en is high.
// Depends on eapg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eapg_div_cell (
	input  wire                            clk,
	input  wire                            en,
	input  wire  [11:0]                    den,
	input  wire  [11:0]                    rem_i,
	input  wire  [eapg_pkg::DIV_BITS-1:0]  num_i,
	input  wire  [31:0]                    quo_i,
	output logic [11:0]                    rem_o,
	output logic [eapg_pkg::DIV_BITS-1:0]  num_o,
	output logic [31:0]                    quo_o
);
	import eapg_pkg::*;

	logic [12:0] trial;
	logic        ge;

	assign trial = {rem_i, num_i[DIV_BITS-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? 12'(trial - {1'b0, den}) : trial[11:0];
			num_o <= {num_i[DIV_BITS-2:0], 1'b0};
			quo_o <= {quo_i[30:0], ge};
		end
	end
endmodule
`default_nettype wire

>>> design/eapg_cordic_cell.sv
// One CORDIC rotation cell, shift and arctangent set by its stage number.
// Depends on eapg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eapg_cordic_cell (
	input  wire                               clk,
	input  wire                               en,
	input  wire  [4:0]                        stage,
	input  wire  signed [eapg_pkg::CW-1:0]    x_i,
	input  wire  signed [eapg_pkg::CW-1:0]    y_i,
	input  wire  signed [eapg_pkg::CW-1:0]    z_i,
	output logic signed [eapg_pkg::CW-1:0]    x_o,
	output logic signed [eapg_pkg::CW-1:0]    y_o,
	output logic signed [eapg_pkg::CW-1:0]    z_o
);
	import eapg_pkg::*;

	logic signed [CW-1:0] xs, ys, at;

	assign xs = x_i >>> stage;
	assign ys = y_i >>> stage;
	assign at = $signed(CW'(atan_turn(stage)));

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[CW-1]) begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - at;
			end else begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + at;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/ellipse_arc_point_generator_unit.sv
// Ellipse arc point generator, top level.
// Depends on eapg_pkg, eapg_div_cell, eapg_cordic_cell.
//
// Usage: write the ellipse registers through cfg_we/cfg_idx/cfg_data while
// the block is idle. Each input beat on s_* carries a point index; each
// output beat on m_* carries the point (x, y) and tlast for the arc end point.
// From input beat to output beat the pipeline is one multiply stage,
// 45 division cells (one quotient bit each), an angle fold stage, 16 CORDIC
// cells and three multiply/sum stages. One beat enters every unstalled cycle.
// The whole pipeline advances together; when m_tready is low with a beat
// waiting, the pipeline holds and s_tready drops, resuming without loss.
// Reset clears all valid flags and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module ellipse_arc_point_generator_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [11:0] point_index
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // [31:0] point_x, [63:32] point_y
	output logic        m_tlast,   // is_final
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_idx,
	input  wire  [31:0] cfg_data
);
	import eapg_pkg::*;

	localparam int FOLD_ST = DIV_BITS + 1;
	localparam int P1_ST   = FOLD_ST + CORDIC_STAGES + 1;

	logic signed [31:0] cx_q, cy_q;
	logic [30:0] semi_q;
	logic [15:0] ratio_q, rot_q, start_q, end_q;
	logic [11:0] seg_q;
	logic [32:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			semi_q  <= 31'd65536;
			ratio_q <= 16'd32768;
			rot_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			seg_q   <= 12'(DEFAULT_SEGMENTS);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_CENTER_X:    cx_q    <= cfg_data;
				REG_CENTER_Y:    cy_q    <= cfg_data;
				REG_SEMI_MAJOR:  semi_q  <= cfg_data[30:0];
				REG_AXIS_RATIO:  ratio_q <= cfg_data[15:0];
				REG_ROT_ANGLE:   rot_q   <= cfg_data[15:0];
				REG_START_PARAM: start_q <= cfg_data[15:0];
				REG_END_PARAM:   end_q   <= cfg_data[15:0];
				REG_SEG_COUNT:   seg_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		b_q <= 33'(({16'd0, semi_q} * {31'd0, ratio_q}) >> 15);
	end

	logic [11:0] n_cfg, idx_sat;
	logic [15:0] sw16;
	logic [16:0] sweep;
	logic        adv;

	assign n_cfg   = (seg_q == 12'd0) ? 12'(DEFAULT_SEGMENTS) : seg_q;
	assign idx_sat = (s_tdata[11:0] > n_cfg) ? n_cfg : s_tdata[11:0];
	assign sw16    = end_q - start_q;
	assign sweep   = (sw16 == 16'd0) ? 17'h10000 : {1'b0, sw16};
	assign adv     = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic vld_q [LAT];
	logic fin_q [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= s_tvalid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_q[0] <= idx_sat == n_cfg;
			for (int k = 1; k < LAT; k++) fin_q[k] <= fin_q[k-1];
		end
	end

	// division: floor(sweep * idx * 65536 / n)
	logic [11:0]         d_rem [DIV_BITS+1];
	logic [DIV_BITS-1:0] d_num [DIV_BITS+1];
	logic [31:0]         d_quo [DIV_BITS+1];

	always_ff @(posedge clk) begin
		if (adv) d_num[0] <= {29'(sweep * {17'd0, idx_sat}), 16'd0};
	end
	assign d_rem[0] = '0;
	assign d_quo[0] = '0;

	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		eapg_div_cell u_cell (
			.clk(clk), .en(adv), .den(n_cfg),
			.rem_i(d_rem[g]), .num_i(d_num[g]), .quo_i(d_quo[g]),
			.rem_o(d_rem[g+1]), .num_o(d_num[g+1]), .quo_o(d_quo[g+1])
		);
	end

	// fold both angles, then run two CORDIC chains side by side
	fold_t ft, fr;
	logic  flip_t_q [CORDIC_STAGES+1];
	logic  flip_r_q [CORDIC_STAGES+1];
	logic signed [CW-1:0] tx [CORDIC_STAGES+1], ty [CORDIC_STAGES+1], tz [CORDIC_STAGES+1];
	logic signed [CW-1:0] rx [CORDIC_STAGES+1], ry [CORDIC_STAGES+1], rz [CORDIC_STAGES+1];

	assign ft = fold_angle({start_q, 16'd0} + d_quo[DIV_BITS]);
	assign fr = fold_angle({rot_q, 16'd0});

	always_ff @(posedge clk) begin
		if (adv) begin
			tx[0] <= GAIN_INV;
			ty[0] <= '0;
			tz[0] <= ft.z;
			rx[0] <= GAIN_INV;
			ry[0] <= '0;
			rz[0] <= fr.z;
			flip_t_q[0] <= ft.flip;
			flip_r_q[0] <= fr.flip;
			for (int k = 1; k <= CORDIC_STAGES; k++) begin
				flip_t_q[k] <= flip_t_q[k-1];
				flip_r_q[k] <= flip_r_q[k-1];
			end
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		eapg_cordic_cell u_t (
			.clk(clk), .en(adv), .stage(5'(g)),
			.x_i(tx[g]), .y_i(ty[g]), .z_i(tz[g]),
			.x_o(tx[g+1]), .y_o(ty[g+1]), .z_o(tz[g+1])
		);
		eapg_cordic_cell u_r (
			.clk(clk), .en(adv), .stage(5'(g)),
			.x_i(rx[g]), .y_i(ry[g]), .z_i(rz[g]),
			.x_o(rx[g+1]), .y_o(ry[g+1]), .z_o(rz[g+1])
		);
	end

	logic signed [CW-1:0] ct, st, cr_c, sr_c, cr_s1, sr_s1, cr_s2, sr_s2;
	logic signed [71:0]   pa_s1, pb_s1, pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [37:0]   lx, ly;
	logic signed [41:0]   t_xc, t_ys, t_xs, t_yc;
	logic signed [43:0]   sum_x, sum_y;

	assign ct   = flip_t_q[CORDIC_STAGES] ? -tx[CORDIC_STAGES] : tx[CORDIC_STAGES];
	assign st   = flip_t_q[CORDIC_STAGES] ? -ty[CORDIC_STAGES] : ty[CORDIC_STAGES];
	assign cr_c = flip_r_q[CORDIC_STAGES] ? -rx[CORDIC_STAGES] : rx[CORDIC_STAGES];
	assign sr_c = flip_r_q[CORDIC_STAGES] ? -ry[CORDIC_STAGES] : ry[CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1 <= $signed({1'b0, semi_q}) * ct;
			pb_s1 <= $signed({1'b0, b_q}) * st;
			cr_s1 <= cr_c;
			sr_s1 <= sr_c;
		end
	end

	assign lx = pa_s1[67:30];
	assign ly = pb_s1[67:30];

	always_ff @(posedge clk) begin
		if (adv) begin
			pxc_s2 <= lx * cr_s1;
			pys_s2 <= ly * sr_s1;
			pxs_s2 <= lx * sr_s1;
			pyc_s2 <= ly * cr_s1;
			cr_s2  <= cr_s1;
			sr_s2  <= sr_s1;
		end
	end

	assign t_xc  = pxc_s2[71:30];
	assign t_ys  = pys_s2[71:30];
	assign t_xs  = pxs_s2[71:30];
	assign t_yc  = pyc_s2[71:30];
	assign sum_x = 44'(cx_q) + 44'(t_xc) - 44'(t_ys);
	assign sum_y = 44'(cy_q) + 44'(t_xs) + 44'(t_yc);

	function automatic logic [31:0] sat32(input logic signed [43:0] v);
		logic [31:0] r;
		if (v > 44'sd2147483647)       r = 32'h7FFFFFFF;
		else if (v < -44'sd2147483648) r = 32'h80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) m_tdata <= {sat32(sum_y), sat32(sum_x)};
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tlast  = fin_q[LAT-1];

	logic unused_ok;
	assign unused_ok = ^{s_tdata[15:12], cr_s2, sr_s2, tz[CORDIC_STAGES], rz[CORDIC_STAGES],
		pa_s1[71:68], pb_s1[71:68], fin_q[P1_ST]};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_q[0] == $past(vld_q[0]) && vld_q[LAT-1] == $past(vld_q[LAT-1]))
		else $error("pipeline moved during stall");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted beat lost at entry");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_BITS] |-> d_rem[DIV_BITS] < n_cfg)
		else $error("division remainder out of range");
endmodule
`default_nettype wire
